>>> hw/rtl/lzw_encoder_variable_width_top_assert.svh
// Assertion macros shared by the encoder RTL.
`ifndef LZW_ENCODER_VARIABLE_WIDTH_TOP_ASSERT_SVH
`define LZW_ENCODER_VARIABLE_WIDTH_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define LZWE_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lzw encoder assertion failed");
`define LZWE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lzw encoder assertion failed");
`else
`define LZWE_ASSERT_IMP(label, clk, rst, pre, post)
`define LZWE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> hw/rtl/lzwe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lzwe_pkg;
   localparam int MAX_CODE_BITS = 12;
   localparam int HASH_DEPTH    = 8192;
   localparam int HASH_BITS     = $clog2(HASH_DEPTH);
   localparam int CODE_W        = MAX_CODE_BITS;
   localparam int NEXT_W        = MAX_CODE_BITS + 1;
   localparam int LIMIT_W       = MAX_CODE_BITS + 2;
   localparam int WIDTH_W       = 5;
   localparam int ACC_W         = MAX_CODE_BITS + 7;
   localparam int CNT_W         = $clog2(ACC_W + 1);
   localparam int FIRST_CODE    = 256;
   localparam int FIRST_WIDTH   = 9;
   localparam int FIRST_LIMIT   = 512;
   localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] prefix;
      logic [7:0]        sym;
      logic [CODE_W-1:0] code;
   } dict_entry_type;

   localparam int ENTRY_W = $bits(dict_entry_type);

   // packer commands from the sequencer
   typedef struct packed {
      logic               append;
      logic [CODE_W-1:0]  code;
      logic [WIDTH_W-1:0] width;
      logic               take;
      logic               take_last;
      logic               flush;
   } pack_cmd_type;

   typedef struct packed {
      logic has_byte;
      logic last_byte;
      logic empty;
      logic slot_free;
   } pack_stat_type;
endpackage
`default_nettype wire

>>> hw/rtl/lzw_encoder_variable_width_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_encoder_variable_width_top_assert.svh"
// LZW encoder with variable code width (9 up to 12 bits), MSB-first packing.
// Request channel: req_in_byte with req_in_last on the final byte of a stream,
// taken on req_valid && req_ready. Response channel: rsp_out_byte packed
// code bits, rsp_out_last on the final byte of the stream, zero-padded when
// the code bits do not fill it. One request is in work at a time. The first
// byte of a stream only opens a string unless it is also the last. A byte that
// extends a known string passes the hash and probe steps, probing the next
// slot while an occupied one does not match (linear probing in a simple
// dual-port dictionary RAM, one probe per cycle). On a dictionary miss the
// code is emitted, then each packed byte is sent out in the drain step before
// the encoder returns to idle.
// The final request of a stream emits the last code, drains, pads if needed, then
// sweeps the 8192-entry dictionary clear, taking no request meanwhile. The
// same sweep runs after reset, so req_ready rises only when it ends.
// A stalled receiver holds the response register; the encoder waits in
// its drain step and takes no new request until every byte of the current
// one has moved into the response register.
module lzw_encoder_variable_width_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_HASH, ST_PROBE, ST_EMIT, ST_DRAIN, ST_CLEAR
   } state_type;

   localparam int HB = lzwe_pkg::HASH_BITS;
   localparam int CW = lzwe_pkg::CODE_W;

   state_type                       state_ff, state_in;
   logic [7:0]                      sym_ff, sym_in;
   logic                            last_ff, last_in;
   logic                            miss_ff, miss_in;
   logic                            fin_ff, fin_in;
   logic                            have_ff, have_in;
   logic [CW-1:0]                   cur_ff, cur_in;
   logic [lzwe_pkg::NEXT_W-1:0]     next_ff, next_in;
   logic [lzwe_pkg::WIDTH_W-1:0]    width_ff, width_in;
   logic [lzwe_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [31:0]                     hash_ff, hash_in;
   logic [HB-1:0]                   probe_ff, probe_in;
   logic [HB-1:0]                   clr_ff, clr_in;

   lzwe_pkg::dict_entry_type        rd_entry, wr_entry;
   logic [lzwe_pkg::ENTRY_W-1:0]    rd_data;
   logic [HB-1:0]                   rd_addr, wr_addr;
   logic                            wr_en;
   logic [31:0]                     hash_mix;
   lzwe_pkg::pack_cmd_type          pcmd;
   lzwe_pkg::pack_stat_type         pstat;
   logic                            grow;
   logic                            width_ok, next_ok;

   assign rd_entry  = lzwe_pkg::dict_entry_type'(rd_data);
   assign hash_mix  = hash_ff ^ (hash_ff >> 15);
   assign req_ready = state_ff == ST_IDLE;
   // widen just before a code goes out
   assign grow = (lzwe_pkg::LIMIT_W'(next_ff) == limit_ff)
                 && (width_ff < lzwe_pkg::WIDTH_W'(lzwe_pkg::MAX_CODE_BITS));

   always_comb begin
      state_in = state_ff;
      sym_in   = sym_ff;
      last_in  = last_ff;
      miss_in  = miss_ff;
      fin_in   = fin_ff;
      have_in  = have_ff;
      cur_in   = cur_ff;
      next_in  = next_ff;
      width_in = width_ff;
      limit_in = limit_ff;
      hash_in  = hash_ff;
      probe_in = probe_ff;
      clr_in   = clr_ff;
      rd_addr  = probe_ff + HB'(1);
      wr_en    = 1'b0;
      wr_addr  = probe_ff;
      wr_entry = '0;
      pcmd     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sym_in  = req_in_byte;
               last_in = req_in_last;
               hash_in = 32'({cur_ff, req_in_byte}) * lzwe_pkg::HASH_MULT;
               if (!have_ff) begin
                  cur_in  = CW'(req_in_byte);
                  have_in = 1'b1;
                  if (req_in_last) begin
                     fin_in   = 1'b1;
                     state_in = ST_EMIT;
                  end
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            rd_addr  = hash_mix[HB-1:0];
            probe_in = hash_mix[HB-1:0];
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (!rd_entry.valid) begin
               miss_in  = 1'b1;
               state_in = ST_EMIT;
            end else if (rd_entry.prefix == cur_ff && rd_entry.sym == sym_ff) begin
               cur_in = rd_entry.code;
               if (last_ff) begin
                  fin_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               // advance to the next slot and probe again
               probe_in = probe_ff + HB'(1);
            end
         end
         ST_EMIT: begin
            if (grow) begin
               width_in = width_ff + lzwe_pkg::WIDTH_W'(1);
               limit_in = limit_ff << 1;
            end
            pcmd.append = 1'b1;
            pcmd.code   = cur_ff;
            pcmd.width  = grow ? width_ff + lzwe_pkg::WIDTH_W'(1) : width_ff;
            if (miss_ff) begin
               miss_in = 1'b0;
               cur_in  = CW'(sym_ff);
               if (next_ff < lzwe_pkg::NEXT_W'(1 << lzwe_pkg::MAX_CODE_BITS)) begin
                  wr_en           = 1'b1;
                  wr_addr         = probe_ff;
                  wr_entry.valid  = 1'b1;
                  wr_entry.prefix = cur_ff;
                  wr_entry.sym    = sym_ff;
                  wr_entry.code   = CW'(next_ff);
                  next_in         = next_ff + lzwe_pkg::NEXT_W'(1);
               end
            end
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (pstat.has_byte) begin
               if (pstat.slot_free) begin
                  // a byte that empties the packer after the final code ends the stream
                  pcmd.take      = 1'b1;
                  pcmd.take_last = fin_ff && pstat.last_byte;
               end
            end else if (last_ff && !fin_ff) begin
               fin_in   = 1'b1;
               state_in = ST_EMIT;
            end else if (fin_ff) begin
               if (pstat.empty) begin
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else if (pstat.slot_free) begin
                  pcmd.flush = 1'b1;
                  clr_in     = '0;
                  state_in   = ST_CLEAR;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            // drop all learned strings and restart the stream state
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_entry = '0;
            clr_in   = clr_ff + HB'(1);
            have_in  = 1'b0;
            cur_in   = '0;
            last_in  = 1'b0;
            fin_in   = 1'b0;
            miss_in  = 1'b0;
            next_in  = lzwe_pkg::NEXT_W'(lzwe_pkg::FIRST_CODE);
            width_in = lzwe_pkg::WIDTH_W'(lzwe_pkg::FIRST_WIDTH);
            limit_in = lzwe_pkg::LIMIT_W'(lzwe_pkg::FIRST_LIMIT);
            if (clr_ff == HB'(lzwe_pkg::HASH_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         have_ff  <= 1'b0;
         last_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         miss_ff  <= 1'b0;
         cur_ff   <= '0;
         next_ff  <= lzwe_pkg::NEXT_W'(lzwe_pkg::FIRST_CODE);
         width_ff <= lzwe_pkg::WIDTH_W'(lzwe_pkg::FIRST_WIDTH);
         limit_ff <= lzwe_pkg::LIMIT_W'(lzwe_pkg::FIRST_LIMIT);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         have_ff  <= have_in;
         last_ff  <= last_in;
         fin_ff   <= fin_in;
         miss_ff  <= miss_in;
         cur_ff   <= cur_in;
         next_ff  <= next_in;
         width_ff <= width_in;
         limit_ff <= limit_in;
      end
      sym_ff   <= sym_in;
      hash_ff  <= hash_in;
      probe_ff <= probe_in;
   end

   lzwe_dict_ram #(
      .DEPTH  (lzwe_pkg::HASH_DEPTH),
      .DATA_W (lzwe_pkg::ENTRY_W)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (lzwe_pkg::ENTRY_W'(wr_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzwe_packer u_packer (
      .clock        (clock),
      .reset        (reset),
      .cmd          (pcmd),
      .stat         (pstat),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   assign width_ok = (width_ff >= lzwe_pkg::WIDTH_W'(lzwe_pkg::FIRST_WIDTH))
                     && (width_ff <= lzwe_pkg::WIDTH_W'(lzwe_pkg::MAX_CODE_BITS));
   assign next_ok  = next_ff <= lzwe_pkg::NEXT_W'(1 << lzwe_pkg::MAX_CODE_BITS);

   `LZWE_ASSERT_IMP(a_width_range, clock, reset, 1'b1, width_ok)
   `LZWE_ASSERT_IMP(a_next_cap, clock, reset, 1'b1, next_ok)
   `LZWE_ASSERT_IMP(a_idle_drained, clock, reset, state_ff == ST_IDLE, !pstat.has_byte)
   `LZWE_ASSERT_NEXT(a_clear_fresh, clock, reset, state_ff == ST_CLEAR, !have_ff)
endmodule
`default_nettype wire

>>> hw/rtl/lzwe_dict_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lzwe_dict_ram #(
   parameter int DEPTH  = 8192,
   parameter int DATA_W = 33
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/lzwe_packer.sv
`timescale 1ns / 1ps
`default_nettype none
module lzwe_packer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lzwe_pkg::pack_cmd_type  cmd,
   output lzwe_pkg::pack_stat_type      stat,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_out_last
);
   logic [lzwe_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [lzwe_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       slot_free;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (cmd.append) begin
         acc_in = lzwe_pkg::ACC_W'((acc_ff << cmd.width)
                                   | lzwe_pkg::ACC_W'(cmd.code));
         cnt_in = cnt_ff + lzwe_pkg::CNT_W'(cmd.width);
      end else if (cmd.take) begin
         byte_in  = 8'(acc_ff >> (cnt_ff - lzwe_pkg::CNT_W'(8)));
         last_in  = cmd.take_last;
         valid_in = 1'b1;
         cnt_in   = cnt_ff - lzwe_pkg::CNT_W'(8);
      end else if (cmd.flush) begin
         // pad the partial byte with zeros
         byte_in  = 8'(acc_ff << (lzwe_pkg::CNT_W'(8) - cnt_ff));
         last_in  = 1'b1;
         valid_in = 1'b1;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      acc_ff  <= acc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign stat.has_byte  = cnt_ff >= lzwe_pkg::CNT_W'(8);
   assign stat.last_byte = cnt_ff == lzwe_pkg::CNT_W'(8);
   assign stat.empty     = cnt_ff == '0;
   assign stat.slot_free = slot_free;
   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_out_last   = last_ff;
endmodule
`default_nettype wire
